// File: rtl/whsp_pkg.sv
// Package: types, codes and magic constants shared by the WAV header parser.
`timescale 1ns / 1ps

package whsp_pkg;

    // Parse phase; the error phases latch a failure until the next first byte
    typedef enum logic [3:0] {
        PH_RIFF       = 4'd0,
        PH_FMTHDR     = 4'd1,
        PH_FMTBODY    = 4'd2,
        PH_FMTSKIP    = 4'd3,
        PH_CHUNKHDR   = 4'd4,
        PH_SKIP       = 4'd5,
        PH_PAYLOAD    = 4'd6,
        PH_DONE       = 4'd7,
        PH_ERR_NORIFF = 4'd8,
        PH_ERR_NOWAVE = 4'd9,
        PH_ERR_NOFMT  = 4'd10,
        PH_ERR_BADFMT = 4'd11,
        PH_ERR_NODATA = 4'd12
    } phase_t;

    // Result status codes
    typedef enum logic [3:0] {
        ST_HEADER  = 4'd0,
        ST_READY   = 4'd1,
        ST_PAYLOAD = 4'd2,
        ST_IGNORED = 4'd3,
        ST_NORIFF  = 4'd4,
        ST_NOWAVE  = 4'd5,
        ST_NOFMT   = 4'd6,
        ST_BADFMT  = 4'd7,
        ST_NODATA  = 4'd8
    } status_t;

    // Chunk ids, first character in the top byte
    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [31:0] FMT_BODY_BYTES = 32'd16;
    localparam logic [15:0] FMT_PCM        = 16'd1;
    localparam logic [15:0] FMT_FLOAT      = 16'd3;

    // Parser state carried from one byte to the next
    typedef struct packed {
        phase_t      phase;
        logic [31:0] pos;
        logic [7:0]  fmt_lo;
        logic        mismatch;
        logic [31:0] fmt_size;
        logic [31:0] chunk_len;
        logic [31:0] rate;
        logic [15:0] bits;
        logic [15:0] chans;
        logic        is_float;
    } parse_state_t;

    localparam parse_state_t RESET_STATE = '{phase: PH_RIFF, default: '0};

    // One result item
    typedef struct packed {
        status_t     status;
        logic [7:0]  payload_byte;
        logic        payload_last;
        logic [31:0] sample_rate;
        logic [15:0] bits_per_sample;
        logic [15:0] num_channels;
        logic [31:0] data_size;
        logic        is_float;
    } result_t;

    // Pick character idx (0 = first) of a chunk id
    function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] idx);
        logic [31:0] shifted;
        shifted = tag >> {~idx, 3'b000};
        return shifted[7:0];
    endfunction

    // Map an error status to its latched phase
    function automatic phase_t err_phase(input status_t code);
        phase_t ph;
        unique case (code)
            ST_NORIFF: ph = PH_ERR_NORIFF;
            ST_NOWAVE: ph = PH_ERR_NOWAVE;
            ST_NOFMT:  ph = PH_ERR_NOFMT;
            ST_BADFMT: ph = PH_ERR_BADFMT;
            default:   ph = PH_ERR_NODATA;
        endcase
        return ph;
    endfunction

    // Map a latched error phase back to its status
    function automatic status_t err_status(input phase_t ph);
        status_t code;
        unique case (ph)
            PH_ERR_NORIFF: code = ST_NORIFF;
            PH_ERR_NOWAVE: code = ST_NOWAVE;
            PH_ERR_NOFMT:  code = ST_NOFMT;
            PH_ERR_BADFMT: code = ST_BADFMT;
            default:       code = ST_NODATA;
        endcase
        return code;
    endfunction

endpackage

// File: rtl/whsp_in_if.sv
// Interface: byte stream channel into the WAV header parser.
`timescale 1ns / 1ps

interface whsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;
    logic       first_byte;
    logic       end_of_stream;

    modport source (output valid, output stream_byte, output first_byte,
                    output end_of_stream, input ready);
    modport sink   (input valid, input stream_byte, input first_byte,
                    input end_of_stream, output ready);
endinterface

// File: rtl/whsp_out_if.sv
// Interface: result channel out of the WAV header parser.
`timescale 1ns / 1ps

interface whsp_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [7:0]  payload_byte;
    logic        payload_last;
    logic [31:0] sample_rate;
    logic [15:0] bits_per_sample;
    logic [15:0] num_channels;
    logic [31:0] data_size;
    logic        is_float;

    modport source (output valid, output status, output payload_byte,
                    output payload_last, output sample_rate, output bits_per_sample,
                    output num_channels, output data_size, output is_float,
                    input ready);
    modport sink   (input valid, input status, input payload_byte,
                    input payload_last, input sample_rate, input bits_per_sample,
                    input num_channels, input data_size, input is_float,
                    output ready);
endinterface

// File: rtl/wav_header_stream_parser_top.sv
// Top level: WAV header parser with payload pass-through, one byte per cycle unless stalled.
//
//  Channel | Modport | Payload                                         | Direction
//  --------+---------+-------------------------------------------------+----------
//  stream  | sink    | stream_byte, first_byte, end_of_stream          | in
//  result  | source  | status, payload_byte, payload_last, sample_rate,| out
//          |         | bits_per_sample, num_channels, data_size,       |
//          |         | is_float                                        |
//
// One request is taken per cycle unless the output register is stalled; its result
// appears in the output register in the cycle after it is taken. It is produced by the
// single state update between the parser state and output registers.
// stream.ready is high while the output register is empty or being drained.
// rst_n clears the parser to expect the RIFF magic and empties the output.
`timescale 1ns / 1ps

module wav_header_stream_parser_top (
    input logic        clk,
    input logic        rst_n,
    whsp_in_if.sink    stream,
    whsp_out_if.source result
);
    import whsp_pkg::*;

    parse_state_t state_reg;
    parse_state_t state_next;
    result_t      result_reg;
    result_t      result_next;
    logic         out_valid_reg;
    logic         accept;

    // Take a request when the output register is free or draining
    assign stream.ready = !out_valid_reg || result.ready;
    assign accept       = stream.valid && stream.ready;

    whsp_step u_step (
        .state         (state_reg),
        .stream_byte   (stream.stream_byte),
        .first_byte    (stream.first_byte),
        .end_of_stream (stream.end_of_stream),
        .state_next    (state_next),
        .res           (result_next)
    );

    // Advance parser state on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RESET_STATE;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    // Hold the result until the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.status          = result_reg.status;
    assign result.payload_byte    = result_reg.payload_byte;
    assign result.payload_last    = result_reg.payload_last;
    assign result.sample_rate     = result_reg.sample_rate;
    assign result.bits_per_sample = result_reg.bits_per_sample;
    assign result.num_channels    = result_reg.num_channels;
    assign result.data_size       = result_reg.data_size;
    assign result.is_float        = result_reg.is_float;

`ifndef SYNTHESIS
    // A latched error keeps its phase until a first byte
    a_err_latched : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !stream.first_byte && state_reg.phase >= PH_ERR_NORIFF)
        |=> (state_reg.phase == $past(state_reg.phase)))
        else $error("latched error phase changed without a first byte");

    // A latched error answers with an error status
    a_err_status : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !stream.first_byte && state_reg.phase >= PH_ERR_NORIFF)
        |=> (result_reg.status >= ST_NORIFF))
        else $error("latched error produced a non-error status");

    // The last mark only rides on header ready or payload
    a_last_kind : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.payload_last)
        |-> (result_reg.status == ST_READY || result_reg.status == ST_PAYLOAD))
        else $error("payload_last on a result that is not ready or payload");

    // Back-pressure only while a result is stalled
    a_ready_stall : assert property (@(posedge clk) disable iff (!rst_n)
        !stream.ready |-> (out_valid_reg && !result.ready))
        else $error("stream stalled with no pending result");
`endif

endmodule

// File: rtl/whsp_step.sv
// Module: per-byte next-state and result logic of the WAV header parser.
`timescale 1ns / 1ps

module whsp_step (
    input  whsp_pkg::parse_state_t state,
    input  logic [7:0]             stream_byte,
    input  logic                   first_byte,
    input  logic                   end_of_stream,
    output whsp_pkg::parse_state_t state_next,
    output whsp_pkg::result_t      res
);
    import whsp_pkg::*;

    parse_state_t cur;
    parse_state_t nxt;
    status_t      st;
    logic [7:0]   pbyte;
    logic         plast;
    logic [32:0]  pos_inc;
    logic [32:0]  fmt_extra;
    logic [32:0]  skip_target;
    logic [15:0]  fmt_code;
    logic         show;

    // Restart from the reset state on a first byte
    assign cur = first_byte ? RESET_STATE : state;

    assign pos_inc     = {1'b0, cur.pos} + 33'd1;
    assign fmt_extra   = {1'b0, cur.fmt_size} - {1'b0, FMT_BODY_BYTES}
                       + {32'd0, cur.fmt_size[0]};
    assign skip_target = {1'b0, cur.chunk_len} + {32'd0, cur.chunk_len[0]};
    assign fmt_code    = {stream_byte, cur.fmt_lo};

    always_comb
    begin
        nxt   = cur;
        st    = ST_HEADER;
        pbyte = 8'd0;
        plast = 1'b0;

        if (cur.phase >= PH_ERR_NORIFF)
        begin
            // Hold the latched error
            st = err_status(cur.phase);
        end
        else if (end_of_stream)
        begin
            // Classify where the file ended
            if (cur.phase == PH_DONE)
            begin
                st = ST_IGNORED;
            end
            else
            begin
                case (cur.phase)
                    PH_RIFF:    st = (cur.pos < 32'd4) ? ST_NORIFF : ST_NOWAVE;
                    PH_FMTHDR:  st = (cur.pos < 32'd4) ? ST_NOFMT : ST_BADFMT;
                    PH_FMTBODY: st = (cur.pos < 32'd2) ? ST_BADFMT : ST_NODATA;
                    default:    st = ST_NODATA;
                endcase
                nxt.phase = err_phase(st);
            end
        end
        else
        begin
            unique case (cur.phase)
                PH_RIFF:
                begin
                    // Check RIFF magic, skip size, check WAVE magic
                    if (cur.pos < 32'd4 && stream_byte != tag_byte(TAG_RIFF, cur.pos[1:0]))
                    begin
                        st        = ST_NORIFF;
                        nxt.phase = PH_ERR_NORIFF;
                    end
                    else if (cur.pos >= 32'd8
                             && stream_byte != tag_byte(TAG_WAVE, cur.pos[1:0]))
                    begin
                        st        = ST_NOWAVE;
                        nxt.phase = PH_ERR_NOWAVE;
                    end
                    else if (cur.pos >= 32'd11)
                    begin
                        nxt.phase = PH_FMTHDR;
                        nxt.pos   = '0;
                    end
                    else
                    begin
                        nxt.pos = pos_inc[31:0];
                    end
                end
                PH_FMTHDR:
                begin
                    // Check fmt magic, then collect the fmt size
                    if (cur.pos < 32'd4 && stream_byte != tag_byte(TAG_FMT, cur.pos[1:0]))
                    begin
                        st        = ST_NOFMT;
                        nxt.phase = PH_ERR_NOFMT;
                    end
                    else
                    begin
                        if (cur.pos >= 32'd4)
                        begin
                            nxt.fmt_size[8*cur.pos[1:0] +: 8] = stream_byte;
                        end
                        if (cur.pos >= 32'd7)
                        begin
                            nxt.phase = PH_FMTBODY;
                            nxt.pos   = '0;
                        end
                        else
                        begin
                            nxt.pos = pos_inc[31:0];
                        end
                    end
                end
                PH_FMTBODY:
                begin
                    // Collect format, channels, rate and bits
                    if (cur.pos == 32'd1 && fmt_code != FMT_PCM && fmt_code != FMT_FLOAT)
                    begin
                        st        = ST_BADFMT;
                        nxt.phase = PH_ERR_BADFMT;
                    end
                    else
                    begin
                        if (cur.pos == 32'd0)
                        begin
                            nxt.fmt_lo = stream_byte;
                        end
                        else if (cur.pos == 32'd1)
                        begin
                            nxt.is_float = (fmt_code == FMT_FLOAT);
                        end
                        else if (cur.pos < 32'd4)
                        begin
                            nxt.chans[8*cur.pos[0] +: 8] = stream_byte;
                        end
                        else if (cur.pos < 32'd8)
                        begin
                            nxt.rate[8*cur.pos[1:0] +: 8] = stream_byte;
                        end
                        else if (cur.pos >= 32'd14)
                        begin
                            nxt.bits[8*cur.pos[0] +: 8] = stream_byte;
                        end

                        if (cur.pos >= 32'd15)
                        begin
                            if (cur.fmt_size > FMT_BODY_BYTES)
                            begin
                                nxt.phase = PH_FMTSKIP;
                                nxt.pos   = '0;
                            end
                            else
                            begin
                                nxt.phase     = PH_CHUNKHDR;
                                nxt.pos       = '0;
                                nxt.mismatch  = 1'b0;
                                nxt.chunk_len = '0;
                            end
                        end
                        else
                        begin
                            nxt.pos = pos_inc[31:0];
                        end
                    end
                end
                PH_FMTSKIP, PH_SKIP:
                begin
                    // Drop extra fmt bytes or an unknown chunk with its pad byte
                    if (pos_inc >= ((cur.phase == PH_FMTSKIP) ? fmt_extra : skip_target))
                    begin
                        nxt.phase     = PH_CHUNKHDR;
                        nxt.pos       = '0;
                        nxt.mismatch  = 1'b0;
                        nxt.chunk_len = '0;
                    end
                    else
                    begin
                        nxt.pos = pos_inc[31:0];
                    end
                end
                PH_CHUNKHDR:
                begin
                    // Compare the chunk id against data, then collect its length
                    if (cur.pos < 32'd4)
                    begin
                        if (stream_byte != tag_byte(TAG_DATA, cur.pos[1:0]))
                        begin
                            nxt.mismatch = 1'b1;
                        end
                        nxt.pos = pos_inc[31:0];
                    end
                    else
                    begin
                        nxt.chunk_len[8*cur.pos[1:0] +: 8] = stream_byte;
                        if (cur.pos < 32'd7)
                        begin
                            nxt.pos = pos_inc[31:0];
                        end
                        else
                        begin
                            nxt.pos = '0;
                            if (!cur.mismatch)
                            begin
                                st = ST_READY;
                                if (nxt.chunk_len == 32'd0)
                                begin
                                    nxt.phase = PH_DONE;
                                    plast     = 1'b1;
                                end
                                else
                                begin
                                    nxt.phase = PH_PAYLOAD;
                                end
                            end
                            else if (nxt.chunk_len == 32'd0)
                            begin
                                nxt.mismatch = 1'b0;
                            end
                            else
                            begin
                                nxt.phase = PH_SKIP;
                            end
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    // Pass the byte through and mark the last one
                    st    = ST_PAYLOAD;
                    pbyte = stream_byte;
                    if (pos_inc >= {1'b0, cur.chunk_len})
                    begin
                        plast     = 1'b1;
                        nxt.phase = PH_DONE;
                    end
                    else
                    begin
                        nxt.pos = pos_inc[31:0];
                    end
                end
                default:
                begin
                    st = ST_IGNORED;
                end
            endcase
        end
    end

    // Show header values from header ready onward
    assign show = (nxt.phase == PH_PAYLOAD) || (nxt.phase == PH_DONE);

    assign state_next          = nxt;
    assign res.status          = st;
    assign res.payload_byte    = pbyte;
    assign res.payload_last    = plast;
    assign res.sample_rate     = show ? nxt.rate : 32'd0;
    assign res.bits_per_sample = show ? nxt.bits : 16'd0;
    assign res.num_channels    = show ? nxt.chans : 16'd0;
    assign res.data_size       = show ? nxt.chunk_len : 32'd0;
    assign res.is_float        = show & nxt.is_float;

endmodule
